### src/ssd_pkg.sv
// Shared types, constants and lookup functions for the seven-segment shift-register driver.
// No dependencies; every other file refers to this package by scoped names.
package ssd_pkg;

    localparam int unsigned NUM_W   = 14;
    localparam int unsigned BCD_W   = 16;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned WORD_W  = 4 * SEG_W;
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QAW     = $clog2(QDEPTH);
    localparam int unsigned QCW     = $clog2(QDEPTH + 1);
    localparam int unsigned BITS_W  = 6;

    localparam logic [NUM_W-1:0] MAX_SHOWN = NUM_W'(9999);
    localparam logic [3:0]       CONV_LAST = 4'(NUM_W - 1);
    localparam logic             CMD_NUMBER = 1'b0;
    localparam logic             CMD_RAW    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } t_front_state;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Active-low segment glyph for a decimal digit (dp g f e d c b a).
    function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] g;
        unique case (digit)
            4'd0:    g = 8'hC0;
            4'd1:    g = 8'hF9;
            4'd2:    g = 8'hA4;
            4'd3:    g = 8'hB0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hF8;
            4'd8:    g = 8'h80;
            4'd9:    g = 8'h90;
            default: g = 8'hFF;
        endcase
        return g;
    endfunction

    // One-hot digit select byte sent after the segment byte.
    function automatic logic [SEG_W-1:0] digit_sel(input logic [1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            2'd0:    s = 8'hF1;
            2'd1:    s = 8'hF2;
            2'd2:    s = 8'hF4;
            default: s = 8'hF8;
        endcase
        return s;
    endfunction

    // One double-dabble step: correct each BCD digit, then shift in the next bit.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < 4; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

endpackage

### src/seven_segment_shift_register_driver.sv
// Top level of the four-digit seven-segment shift-register driver.
// Uses ssd_pkg, ssd_front, ssd_queue and ssd_back.
//
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// request  | start / busy        | i_cmd, i_number, i_pattern_0 .. i_pattern_3
// bit out  | o_valid (strobe)    | o_serial_bit, o_latch_now, o_digit_index, o_last
//
// A request is taken when start is high and busy is low. The front end holds busy
// from acceptance until it pushes the item: a number request first runs fourteen
// double-dabble shifts, and either kind then waits, if need be, for a free queue slot.
// Each request yields 64 output bits on consecutive cycles; the serializer's
// one-bit-per-cycle shift sets the sustained request rate, and queued requests
// follow each other with no idle cycle between them.
// Reset is synchronous and active low; it empties the queue and idles both ends.
// The receiver cannot stall: each bit is shown for exactly one cycle.
module seven_segment_shift_register_driver (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cmd,
    input  logic [ssd_pkg::NUM_W-1:0] i_number,
    input  logic [7:0]                i_pattern_0,
    input  logic [7:0]                i_pattern_1,
    input  logic [7:0]                i_pattern_2,
    input  logic [7:0]                i_pattern_3,
    output logic                      o_valid,
    output logic                      o_serial_bit,
    output logic                      o_latch_now,
    output logic [1:0]                o_digit_index,
    output logic                      o_last
);

    // Queue link: front pushes finished segment words, back pops one per item.
    logic                       push;
    logic                       pop;
    logic [ssd_pkg::WORD_W-1:0] push_word;
    logic [ssd_pkg::WORD_W-1:0] head_word;
    ssd_pkg::t_q_stat           q_stat;

    // Classify the request, saturate and split the number, build the four glyphs.
    ssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_number    (i_number),
        .i_pattern_0 (i_pattern_0),
        .i_pattern_1 (i_pattern_1),
        .i_pattern_2 (i_pattern_2),
        .i_pattern_3 (i_pattern_3),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_word      (push_word)
    );

    // Hold up to two items so the front can run ahead of the serializer.
    ssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .i_pop   (pop),
        .o_data  (head_word),
        .o_stat  (q_stat)
    );

    // Advance one bit per cycle through the four digit frames.
    ssd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (head_word),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_serial_bit  (o_serial_bit),
        .o_latch_now   (o_latch_now),
        .o_digit_index (o_digit_index),
        .o_last        (o_last)
    );

endmodule

### src/ssd_front.sv
// Front end: accepts display requests and turns them into four segment bytes.
// Uses ssd_pkg (state type, glyph table, double-dabble step); feeds ssd_queue.
module ssd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cmd,
    input  logic [ssd_pkg::NUM_W-1:0] i_number,
    input  logic [7:0]                i_pattern_0,
    input  logic [7:0]                i_pattern_1,
    input  logic [7:0]                i_pattern_2,
    input  logic [7:0]                i_pattern_3,
    input  ssd_pkg::t_q_stat          i_q_stat,
    output logic                      o_push,
    output logic [ssd_pkg::WORD_W-1:0] o_word
);

    ssd_pkg::t_front_state r_state, n_state;
    logic [3:0]                    r_cnt, n_cnt;
    logic [ssd_pkg::NUM_W-1:0]     r_bin, n_bin;
    logic [ssd_pkg::BCD_W-1:0]     r_bcd, n_bcd;
    logic                          r_raw, n_raw;
    logic [ssd_pkg::WORD_W-1:0]    r_pat, n_pat;

    assign busy   = (r_state != ssd_pkg::ST_IDLE);
    assign o_push = (r_state == ssd_pkg::ST_PUSH) && !i_q_stat.full;
    assign o_word = r_raw ? r_pat
                          : {ssd_pkg::glyph(r_bcd[15:12]), ssd_pkg::glyph(r_bcd[11:8]),
                             ssd_pkg::glyph(r_bcd[7:4]),   ssd_pkg::glyph(r_bcd[3:0])};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_raw   = r_raw;
        n_pat   = r_pat;
        unique case (r_state)
            ssd_pkg::ST_IDLE: begin
                if (start) begin
                    n_raw = (i_cmd == ssd_pkg::CMD_RAW);
                    n_pat = {i_pattern_0, i_pattern_1, i_pattern_2, i_pattern_3};
                    n_bin = (i_number > ssd_pkg::MAX_SHOWN) ? ssd_pkg::MAX_SHOWN : i_number;
                    n_bcd = '0;
                    n_cnt = '0;
                    n_state = (i_cmd == ssd_pkg::CMD_RAW) ? ssd_pkg::ST_PUSH
                                                          : ssd_pkg::ST_CONV;
                end
            end
            ssd_pkg::ST_CONV: begin
                n_bcd = ssd_pkg::dabble(r_bcd, r_bin[ssd_pkg::NUM_W-1]);
                n_bin = {r_bin[ssd_pkg::NUM_W-2:0], 1'b0};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == ssd_pkg::CONV_LAST) begin
                    n_state = ssd_pkg::ST_PUSH;
                end
            end
            ssd_pkg::ST_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = ssd_pkg::ST_IDLE;
                end
            end
            default: n_state = ssd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_raw <= n_raw;
        r_pat <= n_pat;
    end

endmodule

### src/ssd_queue.sv
// Two-entry queue of segment words between the front end and the serializer.
// Uses ssd_pkg (depth constants, status struct).
module ssd_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [ssd_pkg::WORD_W-1:0] i_data,
    input  logic                       i_pop,
    output logic [ssd_pkg::WORD_W-1:0] o_data,
    output ssd_pkg::t_q_stat           o_stat
);

    logic [ssd_pkg::WORD_W-1:0] r_mem [ssd_pkg::QDEPTH];
    logic [ssd_pkg::QAW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [ssd_pkg::QCW-1:0]    r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == ssd_pkg::QCW'(ssd_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssd_pkg::QCW'(ssd_pkg::QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

### src/ssd_back.sv
// Serializer: shifts four 16-bit digit frames out, one bit per cycle.
// Uses ssd_pkg (digit select table, status struct); takes words from ssd_queue.
module ssd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ssd_pkg::WORD_W-1:0] i_q_data,
    input  ssd_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic                       o_serial_bit,
    output logic                       o_latch_now,
    output logic [1:0]                 o_digit_index,
    output logic                       o_last
);

    logic                         r_active;
    logic [ssd_pkg::BITS_W-1:0]   r_cnt;
    logic [ssd_pkg::WORD_W-1:0]   r_seg;
    logic                         end_item;
    logic [1:0]                   digit;
    logic [3:0]                   bit_pos;
    logic [ssd_pkg::SEG_W-1:0]    seg_byte;
    logic [2*ssd_pkg::SEG_W-1:0]  frame;

    assign end_item = (r_cnt == '1);
    assign o_pop    = (!r_active || end_item) && !i_q_stat.empty;

    assign digit   = r_cnt[5:4];
    assign bit_pos = r_cnt[3:0];

    always_comb begin
        unique case (digit)
            2'd0:    seg_byte = r_seg[31:24];
            2'd1:    seg_byte = r_seg[23:16];
            2'd2:    seg_byte = r_seg[15:8];
            default: seg_byte = r_seg[7:0];
        endcase
    end

    assign frame         = {seg_byte, ssd_pkg::digit_sel(digit)};
    assign o_valid       = r_active;
    assign o_serial_bit  = frame[4'd15 - bit_pos];
    assign o_latch_now   = (bit_pos == 4'd15);
    assign o_digit_index = digit;
    assign o_last        = end_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active) begin
            r_active <= !end_item;
            r_cnt    <= r_cnt + 1'b1;
        end
        if (o_pop) begin
            r_seg <= i_q_data;
        end
    end

`ifndef SYNTHESIS
    a_last_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_latch_now && o_digit_index == 2'd3))
        else $error("last bit outside final frame end");
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !end_item) |=> (r_active && r_cnt == $past(r_cnt) + 1'b1))
        else $error("serializer dropped out mid item");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && end_item && i_q_stat.empty) |=> !r_active)
        else $error("serializer ran past item end with empty queue");
`endif

endmodule

### sim/ssd_frame_checker.sv
// Bit-stream checker for the seven-segment shift-register driver.
// Watches the request and bit channels, predicts each 64-bit frame set; uses ssd_pkg.
module ssd_frame_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic                      i_cmd,
    input  logic [ssd_pkg::NUM_W-1:0] i_number,
    input  logic [7:0]                i_pattern_0,
    input  logic [7:0]                i_pattern_1,
    input  logic [7:0]                i_pattern_2,
    input  logic [7:0]                i_pattern_3,
    input  logic                      i_valid,
    input  logic                      i_serial_bit,
    input  logic                      i_latch_now,
    input  logic [1:0]                i_digit_index,
    input  logic                      i_last,
    output int                        o_pending,
    output int                        o_fail_count
);

    localparam int MAX_PRINTED = 40;
    // Glyphs for digits 9 down to 0, packed so that digit n sits at bits [8n +: 8].
    localparam logic [79:0] GLYPHS = 80'h90_80_F8_82_92_99_B0_A4_F9_C0;

    typedef struct packed {
        logic       serial_bit;
        logic       latch_now;
        logic [1:0] digit_index;
        logic       last;
    } t_shift_bit;

    t_shift_bit bits_due[$];
    int         mismatch_cnt = 0;
    int         bits_seen = 0;

    assign o_fail_count = mismatch_cnt;

    // Segment byte then digit-select byte for digit d of one request.
    function automatic logic [15:0] frame_word(input logic cmd,
                                               input logic [ssd_pkg::NUM_W-1:0] number,
                                               input logic [7:0] p0, input logic [7:0] p1,
                                               input logic [7:0] p2, input logic [7:0] p3,
                                               input int d);
        int unsigned shown;
        int unsigned scale;
        int unsigned digit;
        logic [7:0]  seg;
        logic [3:0]  one_hot;
        shown = (number > 9999) ? 9999 : number;
        case (d)
            0:       scale = 1000;
            1:       scale = 100;
            2:       scale = 10;
            default: scale = 1;
        endcase
        digit = (shown / scale) % 10;
        if (cmd == ssd_pkg::CMD_RAW) begin
            case (d)
                0:       seg = p0;
                1:       seg = p1;
                2:       seg = p2;
                default: seg = p3;
            endcase
        end else begin
            seg = GLYPHS[8*digit +: 8];
        end
        one_hot = 4'b0001 << d;
        return {seg, 4'hF, one_hot};
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_cnt < MAX_PRINTED) begin
            $display("checker: bit %0d: %s", bits_seen, what);
        end
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_shift_bit  seen;
        t_shift_bit  want;
        logic [15:0] word;
        if (!i_rst_n) begin
            bits_due.delete();
        end else begin
            // Check bits before queuing a new request: a bit never belongs to
            // a request taken at the same edge.
            if (i_valid) begin
                seen = '{i_serial_bit, i_latch_now, i_digit_index, i_last};
                if (bits_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected bit=%b latch=%b digit=%0d last=%b",
                                              i_serial_bit, i_latch_now, i_digit_index,
                                              i_last));
                end else begin
                    want = bits_due.pop_front();
                    if (seen.serial_bit !== want.serial_bit
                        || seen.latch_now !== want.latch_now
                        || seen.digit_index !== want.digit_index
                        || seen.last !== want.last) begin
                        report_mismatch($sformatf(
                            "got bit=%b latch=%b digit=%0d last=%b, want %b %b %0d %b",
                            seen.serial_bit, seen.latch_now, seen.digit_index, seen.last,
                            want.serial_bit, want.latch_now, want.digit_index, want.last));
                    end
                end
                bits_seen++;
            end
            if (i_start && !i_busy) begin
                for (int d = 0; d < 4; d++) begin
                    word = frame_word(i_cmd, i_number, i_pattern_0, i_pattern_1,
                                      i_pattern_2, i_pattern_3, d);
                    for (int b = 15; b >= 0; b--) begin
                        bits_due.push_back('{word[b], b == 0, 2'(d), (b == 0) && (d == 3)});
                    end
                end
            end
        end
        o_pending <= bits_due.size();
    end

endmodule

### sim/tb.sv
// Top of the testbench for the seven-segment shift-register driver.
// Drives display requests into the block; ssd_frame_checker predicts and compares the bits.
module tb;

    localparam int TAIL_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 28;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_cmd = ssd_pkg::CMD_NUMBER;
    logic [ssd_pkg::NUM_W-1:0] i_number = '0;
    logic [7:0]                i_pattern_0 = '0;
    logic [7:0]                i_pattern_1 = '0;
    logic [7:0]                i_pattern_2 = '0;
    logic [7:0]                i_pattern_3 = '0;
    logic                      o_valid;
    logic                      o_serial_bit;
    logic                      o_latch_now;
    logic [1:0]                o_digit_index;
    logic                      o_last;

    int pending;
    int fail_count;
    int sender_idle = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    seven_segment_shift_register_driver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_number      (i_number),
        .i_pattern_0   (i_pattern_0),
        .i_pattern_1   (i_pattern_1),
        .i_pattern_2   (i_pattern_2),
        .i_pattern_3   (i_pattern_3),
        .o_valid       (o_valid),
        .o_serial_bit  (o_serial_bit),
        .o_latch_now   (o_latch_now),
        .o_digit_index (o_digit_index),
        .o_last        (o_last)
    );

    ssd_frame_checker frame_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd         (i_cmd),
        .i_number      (i_number),
        .i_pattern_0   (i_pattern_0),
        .i_pattern_1   (i_pattern_1),
        .i_pattern_2   (i_pattern_2),
        .i_pattern_3   (i_pattern_3),
        .i_valid       (o_valid),
        .i_serial_bit  (o_serial_bit),
        .i_latch_now   (o_latch_now),
        .i_digit_index (o_digit_index),
        .i_last        (o_last),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Present one item and hold it until the block takes it. Call only at a
    // rising edge; returns at the edge where the item was accepted.
    task automatic send_request(input logic cmd, input logic [ssd_pkg::NUM_W-1:0] number,
                                input logic [7:0] p0, input logic [7:0] p1,
                                input logic [7:0] p2, input logic [7:0] p3);
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_number    <= number;
        i_pattern_0 <= p0;
        i_pattern_1 <= p1;
        i_pattern_2 <= p2;
        i_pattern_3 <= p3;
        do @(posedge i_clk); while (busy);
    endtask

    // Idle the request side at random, scrambling the ignored payload meanwhile.
    task automatic hold_off();
        while ($urandom_range(0, 99) < sender_idle) begin
            start       <= 1'b0;
            i_cmd       <= 1'($urandom_range(0, 1));
            i_number    <= ssd_pkg::NUM_W'($urandom_range(0, 16383));
            i_pattern_0 <= 8'($urandom_range(0, 255));
            i_pattern_1 <= 8'($urandom_range(0, 255));
            i_pattern_2 <= 8'($urandom_range(0, 255));
            i_pattern_3 <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every predicted bit has come out.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_request();
        logic                      cmd_r;
        logic [ssd_pkg::NUM_W-1:0] number_r;
        cmd_r = $urandom_range(0, 1) ? ssd_pkg::CMD_RAW : ssd_pkg::CMD_NUMBER;
        // Mostly in-range values; some above 9999 to hit saturation.
        if ($urandom_range(0, 9) < 8) begin
            number_r = ssd_pkg::NUM_W'($urandom_range(0, 9999));
        end else begin
            number_r = ssd_pkg::NUM_W'($urandom_range(10000, 16383));
        end
        send_request(cmd_r, number_r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, saturation, every glyph, raw extremes,
        // and payload on the unused side of each command.
        send_request(ssd_pkg::CMD_NUMBER, 14'd0,     8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd9999,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(ssd_pkg::CMD_NUMBER, 14'd10000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd16383, 8'h5A, 8'hA5, 8'h3C, 8'hC3);
        send_request(ssd_pkg::CMD_NUMBER, 14'd1234,  8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd5678,  8'h00, 8'h00, 8'h00, 8'h00);
        drain();
        send_request(ssd_pkg::CMD_NUMBER, 14'd9090,  8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd7,     8'hFF, 8'h00, 8'hFF, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd100,   8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_NUMBER, 14'd8888,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(ssd_pkg::CMD_RAW,    14'd0,     8'h00, 8'h00, 8'h00, 8'h00);
        send_request(ssd_pkg::CMD_RAW,    14'd16383, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(ssd_pkg::CMD_RAW,    14'd9999,  8'h55, 8'hAA, 8'h0F, 8'hF0);
        send_request(ssd_pkg::CMD_RAW,    14'd5461,  8'hA5, 8'h5A, 8'h81, 8'h7E);
        send_request(ssd_pkg::CMD_NUMBER, 14'd10922, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        // Random phases: light sender idling, heavy idling, then none.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       sender_idle = 14;
                1:       sender_idle = 62;
                default: sender_idle = 0;
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Now and then let the queue run dry so items land on an idle block.
                if ($urandom_range(0, 15) == 0) begin
                    drain();
                end
                hold_off();
                send_random_request();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Give up well past the slowest correct run.
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
